// ===== sv/ax25_frame_deframer_core_defines.svh =====
// assertion macros for the rtl, included by axfd_back
`ifndef AX25_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define AX25_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define AXFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AXFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/axfd_pkg.sv =====
package axfd_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 4;
  localparam int DIGI_W = 4;
  localparam int PLEN_W = 9;
  localparam int CRC_W  = 16;
  localparam int FCNT_W = 5;
  localparam int GIDX_W = 3;

  localparam logic [KIND_W-1:0] KIND_DST_CHAR  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SRC_CHAR  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIGI_CHAR = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CONTROL   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_PID       = 4'd7;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 4'd9;

  localparam logic [BYTE_W-1:0] ST_OK        = 8'd0;
  localparam logic [BYTE_W-1:0] ST_SHORT     = 8'd1;
  localparam logic [BYTE_W-1:0] ST_FCS       = 8'd2;
  localparam logic [BYTE_W-1:0] ST_STRUCTURE = 8'd3;

  localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8408;
  localparam logic [FCNT_W-1:0] MIN_FRAME  = 5'd17;
  localparam logic [GIDX_W-1:0] GROUP_CHARS = 3'd6;
  localparam logic [DIGI_W-1:0] DIGI_MAX   = 4'd15;
  localparam logic [6:0]        CHAR_SPACE = 7'h20;
  localparam logic [3:0]        SSID_MASK  = 4'hF;

  typedef enum logic [2:0] {
    PH_DST,
    PH_SRC,
    PH_DIGI,
    PH_CTRL,
    PH_PID,
    PH_PAY
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] position;
    logic [DIGI_W-1:0] digi_number;
    logic [PLEN_W-1:0] payload_length;
    logic              last;
  } res_t;

  typedef struct packed {
    logic rel_v;
    res_t rel;
    logic st_v;
    res_t st;
  } qent_t;

endpackage

// ===== sv/axfd_if.sv =====
interface axfd_in_if;
  import axfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface axfd_out_if;
  import axfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] value;
  logic [BYTE_W-1:0] position;
  logic [DIGI_W-1:0] digi_number;
  logic [PLEN_W-1:0] payload_length;
  logic              last;

  modport source (output valid, output kind, output value, output position,
                  output digi_number, output payload_length, output last, input ready);
  modport sink (input valid, input kind, input value, input position,
                input digi_number, input payload_length, input last, output ready);
endinterface

// ===== sv/axfd_front.sv =====
module axfd_front #(
  parameter int PAYLOAD_MAX = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  axfd_in_if.sink         in_bus,
  output logic            push_valid,
  input  logic            push_ready,
  output axfd_pkg::qent_t push_ent
);
  import axfd_pkg::*;

  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;
  logic [1:0]        held_cnt_r, held_cnt_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [FCNT_W-1:0] fcount_r, fcount_nxt;
  phase_t            phase_r, phase_nxt;
  logic [GIDX_W-1:0] gidx_r, gidx_nxt;
  logic [DIGI_W-1:0] digi_r, digi_nxt;
  logic [PLEN_W-1:0] pay_r, pay_nxt;

  logic              acc;
  logic [CRC_W-1:0]  crc_rel;
  logic [KIND_W-1:0] base_kind;
  logic [DIGI_W-1:0] base_digi;
  logic [6:0]        ch;
  logic              emit;
  res_t              rel;
  res_t              st;
  logic [BYTE_W-1:0] code;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign acc     = in_bus.valid && push_ready;
  assign crc_rel = crc_step(crc_r, held0_r);
  assign ch      = held0_r[7:1];

  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    crc_nxt      = crc_r;
    fcount_nxt   = fcount_r;
    phase_nxt    = phase_r;
    gidx_nxt     = gidx_r;
    digi_nxt     = digi_r;
    pay_nxt      = pay_r;
    emit         = 1'b0;
    rel          = '0;
    st           = '0;
    code         = ST_OK;
    base_kind    = KIND_DST_CHAR;
    base_digi    = '0;

    case (phase_r)
      PH_SRC:  base_kind = KIND_SRC_CHAR;
      PH_DIGI: begin
        base_kind = KIND_DIGI_CHAR;
        base_digi = digi_r;
      end
      default: base_kind = KIND_DST_CHAR;
    endcase

    if (acc) begin
      if (held_cnt_r == 2'd2) begin
        crc_nxt   = crc_rel;
        held0_nxt = held1_r;
        held1_nxt = in_bus.frame_byte;
        case (phase_r)
          PH_DST, PH_SRC, PH_DIGI: begin
            rel.digi_number = base_digi;
            if (gidx_r < GROUP_CHARS) begin
              emit         = (ch != CHAR_SPACE);
              rel.kind     = base_kind;
              rel.value    = {1'b0, ch};
              rel.position = {{(BYTE_W-GIDX_W){1'b0}}, gidx_r};
              gidx_nxt     = gidx_r + 3'd1;
            end else begin
              emit      = 1'b1;
              rel.kind  = base_kind + 4'd1;
              rel.value = {4'h0, ch[3:0] & SSID_MASK};
              gidx_nxt  = '0;
              case (phase_r)
                PH_DST: phase_nxt = PH_SRC;
                PH_SRC: phase_nxt = held0_r[0] ? PH_CTRL : PH_DIGI;
                default: begin
                  if (digi_r < DIGI_MAX) digi_nxt = digi_r + 4'd1;
                  if (held0_r[0]) phase_nxt = PH_CTRL;
                end
              endcase
            end
          end
          PH_CTRL: begin
            emit      = 1'b1;
            rel.kind  = KIND_CONTROL;
            rel.value = held0_r;
            phase_nxt = PH_PID;
          end
          PH_PID: begin
            emit      = 1'b1;
            rel.kind  = KIND_PID;
            rel.value = held0_r;
            phase_nxt = PH_PAY;
          end
          default: begin
            if (pay_r < PLEN_W'(PAYLOAD_MAX)) begin
              emit         = 1'b1;
              rel.kind     = KIND_PAYLOAD;
              rel.value    = held0_r;
              rel.position = pay_r[BYTE_W-1:0];
              pay_nxt      = pay_r + 9'd1;
            end
          end
        endcase
      end else if (held_cnt_r == 2'd1) begin
        held1_nxt    = in_bus.frame_byte;
        held_cnt_nxt = 2'd2;
      end else begin
        held0_nxt    = in_bus.frame_byte;
        held_cnt_nxt = 2'd1;
      end

      if (fcount_r < MIN_FRAME) fcount_nxt = fcount_r + 5'd1;

      if (in_bus.frame_end) begin
        if (fcount_nxt < MIN_FRAME) code = ST_SHORT;
        else if ({held1_nxt, held0_nxt} != ~crc_nxt) code = ST_FCS;
        else if (phase_nxt != PH_PAY) code = ST_STRUCTURE;
        else code = ST_OK;
        st.kind           = KIND_STATUS;
        st.value          = code;
        st.digi_number    = digi_nxt;
        st.payload_length = pay_nxt;
        st.last           = 1'b1;
        held0_nxt    = '0;
        held1_nxt    = '0;
        held_cnt_nxt = '0;
        crc_nxt      = CRC_INIT;
        fcount_nxt   = '0;
        phase_nxt    = PH_DST;
        gidx_nxt     = '0;
        digi_nxt     = '0;
        pay_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r    <= '0;
      held1_r    <= '0;
      held_cnt_r <= '0;
      crc_r      <= CRC_INIT;
      fcount_r   <= '0;
      phase_r    <= PH_DST;
      gidx_r     <= '0;
      digi_r     <= '0;
      pay_r      <= '0;
    end else begin
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      held_cnt_r <= held_cnt_nxt;
      crc_r      <= crc_nxt;
      fcount_r   <= fcount_nxt;
      phase_r    <= phase_nxt;
      gidx_r     <= gidx_nxt;
      digi_r     <= digi_nxt;
      pay_r      <= pay_nxt;
    end
  end

  assign in_bus.ready   = push_ready;
  assign push_valid     = acc && (emit || in_bus.frame_end);
  assign push_ent.rel_v = emit;
  assign push_ent.rel   = rel;
  assign push_ent.st_v  = in_bus.frame_end;
  assign push_ent.st    = st;

endmodule

// ===== sv/axfd_queue.sv =====
module axfd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  axfd_pkg::qent_t push_ent,
  output logic            pop_valid,
  input  logic            pop,
  output axfd_pkg::qent_t pop_ent
);
  import axfd_pkg::*;

  qent_t      ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_ent    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_ent;
  end

endmodule

// ===== sv/axfd_back.sv =====
module axfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  axfd_pkg::qent_t q_ent,
  axfd_out_if.source      out_bus
);
  import axfd_pkg::*;
  `include "ax25_frame_deframer_core_defines.svh"

  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;
  logic pend_v_r, pend_v_nxt;
  res_t pend_r, pend_nxt;
  logic load;

  assign load  = !out_valid_r || out_bus.ready;
  assign q_pop = load && !pend_v_r && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (load) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        pend_v_nxt    = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        if (q_ent.rel_v) begin
          out_nxt    = q_ent.rel;
          pend_v_nxt = q_ent.st_v;
          pend_nxt   = q_ent.st;
        end else begin
          out_nxt = q_ent.st;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.kind           = out_r.kind;
  assign out_bus.value          = out_r.value;
  assign out_bus.position       = out_r.position;
  assign out_bus.digi_number    = out_r.digi_number;
  assign out_bus.payload_length = out_r.payload_length;
  assign out_bus.last           = out_r.last;

  `AXFD_ASSERT_NOW(a_pend_behind_out, pend_v_r, out_valid_r, "pending beat without output beat")
  `AXFD_ASSERT_NOW(a_pend_is_status, pend_v_r, pend_r.last && !out_r.last, "pending beat not a status")
  `AXFD_ASSERT_NEXT(a_pend_drains, pend_v_r && load, !pend_v_r && out_valid_r && out_r.last, "status not forwarded")

endmodule

// ===== sv/ax25_frame_deframer_core.sv =====
// ax.25 frame deframer
// in_bus: one frame byte per beat, frame_end high on the last byte (fcs included).
// out_bus: tagged beats (callsign chars, ssids, control, pid, payload) and one
//   status beat with last high closing every frame.
// the two newest bytes are held back as the possible fcs, so a byte's own beat
// is produced when the byte two places later arrives; the end byte also yields
// the status beat, checked against the crc-16 of all released bytes.
// path: front logic writes the queue when it accepts the byte that causes a beat,
// and the output register then loads the beat from the queue and offers it on
// out_bus (the beat waits in the queue while out_bus stalls).
// throughput: one byte per cycle while the queue has room; the output register
// issues at most one beat per cycle, so an end byte's status beat waits behind
// its field beat. when out_bus stalls the output register holds its beat, the
// queue fills and in_bus.ready falls once both queue entries are taken.
// reset (rst_n low, synchronous) empties queue and output and restarts the
// frame parser at the destination address.
module ax25_frame_deframer_core #(
  parameter int PAYLOAD_MAX = 256
) (
  input logic        clk,
  input logic        rst_n,
  axfd_in_if.sink    in_bus,
  axfd_out_if.source out_bus
);
  import axfd_pkg::*;

  logic  push_valid;
  logic  push_ready;
  qent_t push_ent;
  logic  q_valid;
  logic  q_pop;
  qent_t q_ent;

  axfd_front #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_ent  (push_ent)
  );

  axfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_ent  (push_ent),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_ent   (q_ent)
  );

  axfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .q_ent  (q_ent),
    .out_bus(out_bus)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import axfd_pkg::*;

  localparam int PAYLOAD_CAP = 256;
  localparam int RANDOM_BYTES = 1100;
  localparam int DIRECTED_N = 27;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT = 900;
  localparam int CALM_FROM = 600;
  localparam int CALM_TO = 800;
  localparam int IDLE_PCT = 29;

  localparam logic [KIND_W-1:0] KIND_DST_SSID  = KIND_DST_CHAR + 4'd1;
  localparam logic [KIND_W-1:0] KIND_SRC_SSID  = KIND_SRC_CHAR + 4'd1;
  localparam logic [KIND_W-1:0] KIND_DIGI_SSID = KIND_DIGI_CHAR + 4'd1;

  localparam logic [1:0] FILL_LIT    = 2'd0;
  localparam logic [1:0] FILL_FCS_LO = 2'd1;
  localparam logic [1:0] FILL_FCS_HI = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              e;
  } rx_byte_t;

  typedef struct packed {
    logic [1:0]        fill;
    logic [BYTE_W-1:0] b;
    logic              e;
    logic              typed;
    logic [BYTE_W-1:0] code;
    logic [DIGI_W-1:0] digis;
    logic [PLEN_W-1:0] plen;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  axfd_in_if  in_ch ();
  axfd_out_if out_ch ();

  ax25_frame_deframer_core #(.PAYLOAD_MAX(PAYLOAD_CAP)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always #5 clk = ~clk;

  // deframer state as the block should hold it
  logic [BYTE_W-1:0] hold_buf [2];
  logic [1:0]        hold_fill;
  logic [CRC_W-1:0]  crc_acc;
  logic [FCNT_W-1:0] byte_tally;
  phase_t            field;
  logic [GIDX_W-1:0] group_pos;
  logic [DIGI_W-1:0] digi_groups;
  logic [PLEN_W-1:0] kept_len;

  res_t       expected_beats [$];
  rx_byte_t   byte_plan [$];
  logic [7:0] frame_body [$];
  dir_row_t   directed_rows [DIRECTED_N];

  int errors = 0;
  int in_taken = 0;
  int quiet = 0;
  wire calm = (in_taken >= CALM_FROM) && (in_taken < CALM_TO);

  function automatic logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    int k;
    x = c ^ {8'd0, b};
    for (k = 0; k < 8; k++)
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  function automatic res_t make_beat(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value,
                                     logic [BYTE_W-1:0] pos, logic [DIGI_W-1:0] digi,
                                     logic [PLEN_W-1:0] plen, logic last);
    res_t r;
    r.kind = kind;
    r.value = value;
    r.position = pos;
    r.digi_number = digi;
    r.payload_length = plen;
    r.last = last;
    return r;
  endfunction

  function automatic void clear_frame();
    hold_buf[0] = '0;
    hold_buf[1] = '0;
    hold_fill = '0;
    crc_acc = CRC_INIT;
    byte_tally = '0;
    field = PH_DST;
    group_pos = '0;
    digi_groups = '0;
    kept_len = '0;
  endfunction

  function automatic void take_address(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] char_kind,
                                       logic [KIND_W-1:0] ssid_kind, logic [DIGI_W-1:0] digi);
    if (group_pos < GROUP_CHARS) begin
      if (b[7:1] != CHAR_SPACE)
        expected_beats.push_back(make_beat(char_kind, {1'b0, b[7:1]}, {5'd0, group_pos},
                                           digi, '0, 1'b0));
      group_pos = group_pos + 3'd1;
    end else begin
      expected_beats.push_back(make_beat(ssid_kind, {4'd0, b[4:1] & SSID_MASK}, '0,
                                         digi, '0, 1'b0));
      group_pos = '0;
      case (field)
        PH_DST: begin
          field = PH_SRC;
        end
        PH_SRC: begin
          field = b[0] ? PH_CTRL : PH_DIGI;
        end
        default: begin
          if (digi_groups < DIGI_MAX)
            digi_groups = digi_groups + 4'd1;
          if (b[0])
            field = PH_CTRL;
        end
      endcase
    end
  endfunction

  function automatic void release_byte(logic [BYTE_W-1:0] b);
    crc_acc = crc_next(crc_acc, b);
    case (field)
      PH_DST: take_address(b, KIND_DST_CHAR, KIND_DST_SSID, '0);
      PH_SRC: take_address(b, KIND_SRC_CHAR, KIND_SRC_SSID, '0);
      PH_DIGI: take_address(b, KIND_DIGI_CHAR, KIND_DIGI_SSID, digi_groups);
      PH_CTRL: begin
        expected_beats.push_back(make_beat(KIND_CONTROL, b, '0, '0, '0, 1'b0));
        field = PH_PID;
      end
      PH_PID: begin
        expected_beats.push_back(make_beat(KIND_PID, b, '0, '0, '0, 1'b0));
        field = PH_PAY;
      end
      default: begin
        if (kept_len < PAYLOAD_CAP) begin
          expected_beats.push_back(make_beat(KIND_PAYLOAD, b, kept_len[7:0], '0, '0, 1'b0));
          kept_len = kept_len + 9'd1;
        end
      end
    endcase
  endfunction

  function automatic void deframe_byte(logic [BYTE_W-1:0] b, logic e);
    logic [CRC_W-1:0]  fcs;
    logic [BYTE_W-1:0] code;
    if (hold_fill >= 2'd2) begin
      release_byte(hold_buf[0]);
      hold_buf[0] = hold_buf[1];
      hold_buf[1] = b;
    end else begin
      hold_buf[hold_fill[0]] = b;
      hold_fill = hold_fill + 2'd1;
    end
    if (byte_tally < MIN_FRAME)
      byte_tally = byte_tally + 5'd1;
    if (e) begin
      fcs = {hold_buf[1], hold_buf[0]};
      if (byte_tally < MIN_FRAME)
        code = ST_SHORT;
      else if (fcs != ~crc_acc)
        code = ST_FCS;
      else if (field != PH_PAY)
        code = ST_STRUCTURE;
      else
        code = ST_OK;
      expected_beats.push_back(make_beat(KIND_STATUS, code, '0, digi_groups, kept_len, 1'b1));
      clear_frame();
    end
  endfunction

  function automatic void note_failure(string what, res_t want, res_t got);
    errors++;
    if (errors <= 10)
      $display({"%s: want kind=%0d value=%0d pos=%0d digi=%0d plen=%0d last=%0d,",
                " got kind=%0d value=%0d pos=%0d digi=%0d plen=%0d last=%0d"},
               what, want.kind, want.value, want.position, want.digi_number,
               want.payload_length, want.last, got.kind, got.value, got.position,
               got.digi_number, got.payload_length, got.last);
  endfunction

  // monitor, checker and watchdog
  always @(posedge clk) begin
    res_t got;
    res_t want;
    logic in_hit;
    logic out_hit;
    if (rst_n) begin
      in_hit = in_ch.valid && in_ch.ready;
      out_hit = out_ch.valid && out_ch.ready;
      if (in_hit) begin
        deframe_byte(in_ch.frame_byte, in_ch.frame_end);
        if (in_taken < DIRECTED_N && directed_rows[in_taken].typed)
          expected_beats[expected_beats.size()-1] =
            make_beat(KIND_STATUS, directed_rows[in_taken].code, '0,
                      directed_rows[in_taken].digis, directed_rows[in_taken].plen, 1'b1);
        in_taken++;
      end
      if (out_hit) begin
        got = make_beat(out_ch.kind, out_ch.value, out_ch.position, out_ch.digi_number,
                        out_ch.payload_length, out_ch.last);
        if (expected_beats.size() == 0) begin
          note_failure("unexpected beat", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.position !== want.position || got.digi_number !== want.digi_number ||
              got.payload_length !== want.payload_length || got.last !== want.last)
            note_failure("mismatch", want, got);
        end
      end
      if (in_hit || out_hit)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    bit held_done;
    held_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held_done && in_taken >= HOLD_AT) begin
        held_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic add_group(input logic ext);
    int k;
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(3) == 0)
        frame_body.push_back({7'h20, 1'($urandom_range(1))});
      else
        frame_body.push_back(8'($urandom_range(255)));
    end
    frame_body.push_back({7'($urandom_range(127)), ext});
  endtask

  // digis below zero: random shape, otherwise a clean frame; a negative digis or paylen is drawn at random
  task automatic plan_frame(input int digis, input int paylen);
    int shape;
    int cut;
    int k;
    logic [CRC_W-1:0] crc;
    frame_body.delete();
    shape = (digis < 0) ? $urandom_range(99) : 99;
    if (shape < 12) begin
      repeat ($urandom_range(1, 30)) frame_body.push_back(8'($urandom_range(255)));
    end else begin
      if (digis < 0)
        digis = ($urandom_range(9) == 0) ? $urandom_range(3, 16) : $urandom_range(0, 2);
      if (paylen < 0)
        paylen = $urandom_range(0, 24);
      add_group(1'($urandom_range(1)));
      add_group(digis == 0);
      for (k = 0; k < digis; k++)
        add_group(k == digis - 1);
      frame_body.push_back(8'($urandom_range(255)));
      frame_body.push_back(8'($urandom_range(255)));
      repeat (paylen) frame_body.push_back(8'($urandom_range(255)));
      if (shape < 26) begin
        cut = $urandom_range(1) ? $urandom_range(13, 23) : $urandom_range(0, frame_body.size());
        while (frame_body.size() > cut)
          void'(frame_body.pop_back());
      end
      crc = CRC_INIT;
      for (k = 0; k < frame_body.size(); k++)
        crc = crc_next(crc, frame_body[k]);
      crc = ~crc;
      if (shape >= 26 && shape < 32)
        crc = crc ^ (16'd1 << $urandom_range(15));
      frame_body.push_back(crc[7:0]);
      frame_body.push_back(crc[15:8]);
    end
    for (k = 0; k < frame_body.size(); k++)
      byte_plan.push_back({frame_body[k], k == frame_body.size() - 1});
  endtask

  task automatic build_plan();
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    int i;
    int n;
    crc = CRC_INIT;
    for (i = 0; i < DIRECTED_N; i++) begin
      case (directed_rows[i].fill)
        FILL_FCS_LO: b = ~crc[7:0];
        FILL_FCS_HI: b = ~crc[15:8];
        default: begin
          b = directed_rows[i].b;
          crc = crc_next(crc, b);
        end
      endcase
      byte_plan.push_back({b, directed_rows[i].e});
      if (directed_rows[i].e)
        crc = CRC_INIT;
    end
    n = 0;
    while (byte_plan.size() < DIRECTED_N + RANDOM_BYTES) begin
      case (n)
        3: plan_frame(17, 4);
        6: plan_frame(0, 262);
        9: plan_frame(1, PAYLOAD_CAP);
        default: plan_frame(-1, -1);
      endcase
      n++;
    end
  endtask

  task automatic feed_bytes();
    int i;
    int drained_at;
    i = 0;
    drained_at = -1;
    while (i < byte_plan.size()) begin
      if ((i == DIRECTED_N || i == DRAIN_AT) && drained_at != i) begin
        drained_at = i;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
      end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.frame_byte <= byte_plan[i].b;
        in_ch.frame_end <= byte_plan[i].e;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        i++;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.frame_byte <= '0;
    in_ch.frame_end <= 1'b0;
    clear_frame();
    directed_rows = '{
      // one byte frame straight after reset
      '{FILL_LIT, 8'h00, 1'b1, 1'b1, ST_SHORT, 4'd0, 9'd0},
      // destination: extreme bytes, both space forms, extension bit set
      '{FILL_LIT, 8'hFF, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h00, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h41, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h82, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'hA6, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'hE1, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      // source, more groups follow
      '{FILL_LIT, 8'h9C, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h6E, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h60, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      // one digipeater, last in path
      '{FILL_LIT, 8'hAE, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h92, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h88, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h8A, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h64, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h40, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'h63, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      // control, pid, one payload byte, good fcs
      '{FILL_LIT, 8'h03, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'hF0, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_LIT, 8'hFF, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_FCS_LO, 8'h00, 1'b0, 1'b0, ST_OK, 4'd0, 9'd0},
      '{FILL_FCS_HI, 8'h00, 1'b1, 1'b1, ST_OK, 4'd1, 9'd1}
    };
    build_plan();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (!rst_n) @(posedge clk);
    feed_bytes();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
